/* rtl/asy_pkg.sv */
// Shared types, codes and the sine table function of the additive synthesizer.
`timescale 1ns / 1ps
package asy_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_SAMPLE  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SAMPLE_RATE   = 1'b0;
  localparam logic CFG_TOTAL_SAMPLES = 1'b1;

  localparam int unsigned SampleRateReset   = 44100;
  localparam int unsigned TotalSamplesReset = 44100;

  // A quarter turn in radians.
  localparam real HalfPi = 3.14159265358979323846 / 2.0;

  // Control shared by every oscillator cell.
  typedef struct packed {
    logic shift;  // Rotate the ring by one cell.
    logic clear;  // Zero every phase (restart).
  } cell_ctrl_t;

  // Quarter-wave entry k of a table with 2^qbits entries per quarter,
  // truncated toward zero. Evaluated only on constants at elaboration.
  function automatic logic [14:0] quarter_val(int k, int qbits);
    real x;
    int  v;
    if (k == 0) return 15'd0;
    if (k == (1 << qbits)) return 15'd32767;
    x = HalfPi * real'(k) * (2.0 ** (-qbits));
    v = $rtoi(32767.0 * $sin(x));
    return 15'(v);
  endfunction

endpackage

/* rtl/asy_cell.sv */
// One oscillator cell: increment, weight and phase of a partial in the ring.
`timescale 1ns / 1ps
module asy_cell #(
  parameter int PhaseBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  asy_pkg::cell_ctrl_t  ctrl_i,
  input  logic                 load_i,
  input  logic [PhaseBits-1:0] load_inc_i,
  input  logic [15:0]          load_weight_i,
  input  logic [PhaseBits-1:0] inc_i,
  input  logic [15:0]          weight_i,
  input  logic [PhaseBits-1:0] phase_i,
  output logic [PhaseBits-1:0] inc_o,
  output logic [15:0]          weight_o,
  output logic [PhaseBits-1:0] phase_o
);

  logic [PhaseBits-1:0] inc_q, phase_q;
  logic [15:0]          weight_q;

  // Shift from the neighbor, load from a write, or clear on restart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q    <= '0;
      weight_q <= '0;
      phase_q  <= '0;
    end else if (ctrl_i.shift) begin
      inc_q    <= inc_i;
      weight_q <= weight_i;
      phase_q  <= phase_i;
    end else begin
      if (load_i) begin
        inc_q    <= load_inc_i;
        weight_q <= load_weight_i;
      end
      if (ctrl_i.clear) begin
        phase_q <= '0;
      end
    end
  end

  assign inc_o    = inc_q;
  assign weight_o = weight_q;
  assign phase_o  = phase_q;

endmodule

/* rtl/asy_div.sv */
// Restoring divider, one quotient bit per cycle, shared by both divisions.
`timescale 1ns / 1ps
module asy_div #(
  parameter int NumW = 48,
  parameter int DenW = 22
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] n_q;
  logic [DenW-1:0] den_q, r_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   r_sh, r_sub;
  logic            qbit;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    r_sh  = {r_q, n_q[NumW-1]};
    r_sub = r_sh - {1'b0, den_q};
    qbit  = (r_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      r_q   <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[NumW-2:0], qbit};
      r_q <= qbit ? r_sub[DenW-1:0] : r_sh[DenW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = n_q;

  // A start never lands on a division in progress.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  // Done follows exactly one busy period.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without busy");
  // The remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> (r_q < den_q) || (den_q == '0))
    else $error("remainder out of range");

endmodule

/* rtl/additive_sine_synthesizer_core.sv */
// Top level: oscillator ring, sine lookup, accumulator, divider and control.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | action, partial_index, frequency, amplitude
//  out     | output    | out_valid/out_ready | sample, last
//  cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// A write item runs the increment division in the one-bit-per-cycle divider, which is
// NW bits wide, NW = max(PHASE_BITS + 16, 33 + log2(PARTIALS)). A sample item rotates
// the ring one cell per cycle past the multiplier, then runs the divider.
// Restart clears the phases as it is accepted. One item is worked at a time; a finished sample waits
// in the output register, and the next item is accepted meanwhile.
// Reset clears all oscillator state at once; there is no clearing pass.
`timescale 1ns / 1ps
module additive_sine_synthesizer_core #(
  parameter int PARTIALS        = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_action_i,
  input  logic [2:0]  in_partial_index_i,
  input  logic [23:0] in_frequency_i,
  input  logic [15:0] in_amplitude_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] out_sample_o,
  output logic        out_last_o
);

  localparam int PB    = PHASE_BITS;
  localparam int STB   = SINE_TABLE_BITS;
  localparam int QB    = STB - 2;
  localparam int QLEN  = 1 << QB;
  localparam int LogP  = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
  localparam int CW    = LogP;
  localparam int WsW   = 16 + $clog2(PARTIALS + 1);
  localparam int AccW  = 33 + LogP;
  localparam int IncNW = PB + 16;
  localparam int NW    = (IncNW > AccW) ? IncNW : AccW;
  localparam int DW    = (WsW > 18) ? WsW : 18;

  typedef enum logic [2:0] {
    S_IDLE, S_INC, S_RUN, S_DRAIN, S_NSTART, S_NORM, S_DONE
  } state_e;

  state_e st_q;

  // Configuration registers.
  logic [17:0] sample_rate_q;
  logic [31:0] total_samples_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q   <= 18'(asy_pkg::SampleRateReset);
      total_samples_q <= 32'(asy_pkg::TotalSamplesReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        asy_pkg::CFG_SAMPLE_RATE:   sample_rate_q   <= cfg_wdata_i[17:0];
        asy_pkg::CFG_TOTAL_SAMPLES: total_samples_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Quarter-wave sine table, fixed at elaboration.
  logic [14:0] qw [QLEN+1];
  for (genvar k = 0; k <= QLEN; k++) begin : g_qw
    assign qw[k] = asy_pkg::quarter_val(k, QB);
  end

  // Captured item fields.
  logic [2:0]  idx_q;
  logic [15:0] amp_q;

  // Oscillator ring.
  asy_pkg::cell_ctrl_t  ctrl;
  logic [PARTIALS-1:0]  load;
  logic [PB-1:0]        inc_w   [PARTIALS];
  logic [15:0]          wgt_w   [PARTIALS];
  logic [PB-1:0]        ph_w    [PARTIALS];
  logic [PB-1:0]        inc_in  [PARTIALS];
  logic [15:0]          wgt_in  [PARTIALS];
  logic [PB-1:0]        ph_in   [PARTIALS];
  logic [PB-1:0]        inc_res;
  logic                 last_q;

  for (genvar i = 0; i < PARTIALS; i++) begin : g_cell
    if (i == PARTIALS - 1) begin : g_tail
      assign inc_in[i] = inc_w[0];
      assign wgt_in[i] = wgt_w[0];
      assign ph_in[i]  = last_q ? '0 : ph_w[0] + inc_w[0];
    end else begin : g_mid
      assign inc_in[i] = inc_w[i+1];
      assign wgt_in[i] = wgt_w[i+1];
      assign ph_in[i]  = ph_w[i+1];
    end
    asy_cell #(.PhaseBits(PB)) u_cell (
      .clk_i, .rst_ni,
      .ctrl_i       (ctrl),
      .load_i       (load[i]),
      .load_inc_i   (inc_res),
      .load_weight_i(amp_q),
      .inc_i        (inc_in[i]),
      .weight_i     (wgt_in[i]),
      .phase_i      (ph_in[i]),
      .inc_o        (inc_w[i]),
      .weight_o     (wgt_w[i]),
      .phase_o      (ph_w[i])
    );
  end

  // Sine lookup and weighting of the head cell.
  logic [STB-1:0]      sidx;
  logic [QB:0]         qk;
  logic [14:0]         smag;
  logic signed [15:0]  sval;
  logic signed [32:0]  prod;
  always_comb begin
    sidx = ph_w[0][PB-1 -: STB];
    qk   = sidx[STB-2] ? (QB+1)'(QLEN) - {1'b0, sidx[QB-1:0]} : {1'b0, sidx[QB-1:0]};
    smag = qw[qk];
    sval = sidx[STB-1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    prod = $signed({1'b0, wgt_w[0]}) * sval;
  end

  // Divider operands.
  logic             div_start, div_busy, div_done;
  logic [NW-1:0]    div_num, quot;
  logic [DW-1:0]    div_den;
  logic signed [AccW-1:0] acc_q;
  logic signed [32:0]     prod_q;
  logic                   pv_q;
  logic [AccW-1:0]        acc_mag;
  logic [WsW-1:0]         ws_q;
  logic                   neg_q;

  // The increment division starts at the accepting edge, so it takes the
  // frequency straight from the input.
  assign acc_mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  always_comb begin
    if (st_q == S_NSTART) begin
      div_num = NW'(acc_mag);
      div_den = (ws_q == '0) ? DW'(1) : DW'(ws_q);
    end else begin
      div_num = NW'({in_frequency_i, {(PB - 8){1'b0}}});
      div_den = (sample_rate_q == '0) ? DW'(1) : DW'(sample_rate_q);
    end
  end

  asy_div #(.NumW(NW), .DenW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign inc_res = quot[PB-1:0];

  // Control of the ring and the divider.
  logic [CW-1:0] cnt_q;
  logic [31:0]   scount_q;
  logic          in_fire, out_free, write_ok, out_load;
  logic [15:0]   qmag;

  assign in_ready_o = (st_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign out_load   = ((st_q == S_NORM && div_done) || st_q == S_DONE) && out_free;
  assign write_ok   = 32'(idx_q) < PARTIALS;
  assign qmag       = quot[15:0];
  assign div_start  = (st_q == S_NSTART) ||
                      (in_fire && in_action_i == asy_pkg::ACT_WRITE);
  assign ctrl.shift = (st_q == S_RUN);
  assign ctrl.clear = in_fire && in_action_i == asy_pkg::ACT_RESTART;

  always_comb begin
    load = '0;
    if (st_q == S_INC && div_done && write_ok) begin
      load[LogP'(idx_q)] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q  <= in_partial_index_i;
      amp_q  <= in_amplitude_i;
    end
    prod_q <= prod;
    if (in_fire) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (st_q == S_NSTART) begin
      neg_q <= acc_q[AccW-1];
    end
  end

  // State machine with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      last_q       <= 1'b0;
      scount_q     <= '0;
      ws_q         <= '0;
      out_valid_o  <= 1'b0;
      out_sample_o <= '0;
      out_last_o   <= 1'b0;
    end else begin
      pv_q <= (st_q == S_RUN);
      if (out_valid_o && out_ready_i && !out_load) begin
        out_valid_o <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_action_i)
              asy_pkg::ACT_WRITE: st_q <= S_INC;
              asy_pkg::ACT_RESTART: scount_q <= '0;
              asy_pkg::ACT_SAMPLE: begin
                st_q   <= S_RUN;
                cnt_q  <= '0;
                last_q <= (scount_q + 32'd1) == total_samples_q;
              end
              default: ;
            endcase
          end
        end
        S_INC: begin
          if (div_done) begin
            if (write_ok) begin
              ws_q <= ws_q - WsW'(wgt_w[LogP'(idx_q)]) + WsW'(amp_q);
            end
            st_q <= S_IDLE;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(PARTIALS - 1)) begin
            st_q     <= S_DRAIN;
            scount_q <= last_q ? '0 : scount_q + 32'd1;
          end
        end
        S_DRAIN: st_q <= S_NSTART;
        S_NSTART: st_q <= S_NORM;
        S_NORM, S_DONE: begin
          if (out_load) begin
            out_valid_o  <= 1'b1;
            out_sample_o <= neg_q ? -$signed(qmag) : $signed(qmag);
            out_last_o   <= last_q;
            st_q         <= S_IDLE;
          end else if (div_done) begin
            st_q <= S_DONE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // The ring only rotates while no item can enter.
  a_shift_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift |-> !in_ready_o) else $error("ring rotated while accepting");
  // A sample marked last leaves the sample count at zero.
  a_last_resets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DRAIN && last_q |-> scount_q == '0) else $error("count not reset");
  // The divider is idle whenever the block is idle.
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> !div_busy) else $error("divider busy while idle");

endmodule
